// ----- rtl/lsdb_pkg.sv -----
// Shared types and constants of the lidar sample decoder and binner.
package lsdb_pkg;

  localparam int ANGLE_BINS = 360;
  localparam int BIN_W      = 9;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  localparam logic [BIN_W-1:0] BIN_LIMIT = 9'd360;
  localparam logic [BIN_W-1:0] BIN_LAST  = 9'd359;
  localparam logic [9:0]       ANG_WRAP  = 10'd360;

  // input action codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // result kind codes
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // one operation handed from front to back
  typedef struct packed {
    logic             kind;
    logic [BIN_W-1:0] bin;
    logic [15:0]      distance;
    logic [5:0]       quality;
    logic             start;
  } op_t;

endpackage

// ----- rtl/lidar_sample_decoder_binner_core.sv -----
// Top level of the lidar sample decoder and angle binner.
//
// Takes one request per cycle: either a received lidar byte (action 0) or a
// read of one angle bin (action 1). Bytes are only used while scan_enable is
// set; five-byte samples that pass the check and start-flag test are binned
// to whole degrees (Q6 angle rounded half up, wrapped into 0..359) and their
// raw quarter-mm distance is stored in a 360-entry table and reported.
// Reads work with scan_enable set or clear and see every sample accepted
// before them. The front end handles the byte window and angle math in the
// cycle a request is taken, a four-entry op queue decouples it from the back
// end, and the back end owns the table memory (one port, registered read)
// and the result register. Sustained rate is one request per cycle while
// out_stall is low; with an idle output, a taken request passes through the
// op queue into the result register, which raises out_valid. After reset a
// clearing pass zeroes all 360 table entries, during which in_stall is high;
// cfg writes are taken throughout. in_stall also rises when the op queue is
// full, which happens only while out_stall holds results back.
module lidar_sample_decoder_binner_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic [7:0]                 in_rx_byte,
  input  logic [lsdb_pkg::BIN_W-1:0] in_read_bin,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_result_kind,
  output logic [lsdb_pkg::BIN_W-1:0] out_angle_bin,
  output logic [15:0]                out_distance_raw,
  output logic [5:0]                 out_sample_quality,
  output logic                       out_scan_start
);

  logic          accept;
  logic          push;
  lsdb_pkg::op_t push_op;
  logic          q_empty, q_full, q_pop;
  lsdb_pkg::op_t q_head;
  logic          busy;

  // stall depends only on registered state: clear pass or queue full
  assign in_stall = q_full || busy;
  assign accept   = in_valid && !in_stall;

  lsdb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .action      (in_action),
    .rx_byte     (in_rx_byte),
    .read_bin    (in_read_bin),
    .push        (push),
    .push_op     (push_op)
  );

  lsdb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (q_pop),
    .empty   (q_empty),
    .full    (q_full),
    .head_op (q_head)
  );

  lsdb_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .busy               (busy),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_angle_bin      (out_angle_bin),
    .out_distance_raw   (out_distance_raw),
    .out_sample_quality (out_sample_quality),
    .out_scan_start     (out_scan_start)
  );

endmodule

// ----- rtl/lsdb_front.sv -----
// Front end: byte window, sample check, angle binning and op generation.
module lsdb_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  logic                          accept,
  input  logic                          action,
  input  logic [7:0]                    rx_byte,
  input  logic [lsdb_pkg::BIN_W-1:0]    read_bin,
  output logic                          push,
  output lsdb_pkg::op_t                 push_op
);

  logic        scan_en_r;
  logic [7:0]  win_r [4];
  logic [7:0]  win_nxt [4];
  logic [2:0]  cnt_r, cnt_nxt;

  logic        ok;
  logic [14:0] q6;
  logic [15:0] q6_rnd;
  logic [9:0]  ang;
  logic [9:0]  ang_w;

  assign ok     = win_r[1][0] && (win_r[0][0] ^ win_r[0][1]);
  assign q6     = {win_r[2], win_r[1][7:1]};
  assign q6_rnd = {1'b0, q6} + 16'd32;
  assign ang    = q6_rnd[15:6];
  assign ang_w  = (ang >= lsdb_pkg::ANG_WRAP) ? (ang - lsdb_pkg::ANG_WRAP) : ang;

  always_comb begin
    win_nxt = win_r;
    cnt_nxt = cnt_r;
    push    = 1'b0;
    push_op = '0;
    if (accept) begin
      if (action == lsdb_pkg::ACT_READ) begin
        push         = 1'b1;
        push_op.kind = lsdb_pkg::KIND_READ;
        push_op.bin  = read_bin;
      end else if (scan_en_r) begin
        if (cnt_r < 3'd4) begin
          win_nxt[cnt_r[1:0]] = rx_byte;
          cnt_nxt             = cnt_r + 3'd1;
        end else if (ok) begin
          cnt_nxt          = 3'd0;
          push             = 1'b1;
          push_op.kind     = lsdb_pkg::KIND_SAMPLE;
          push_op.bin      = ang_w[8:0];
          push_op.distance = {rx_byte, win_r[3]};
          push_op.quality  = win_r[0][7:2];
          push_op.start    = win_r[0][0];
        end else begin
          // slide by one byte, keep four held
          win_nxt[0] = win_r[1];
          win_nxt[1] = win_r[2];
          win_nxt[2] = win_r[3];
          win_nxt[3] = rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_en_r <= 1'b0;
      cnt_r     <= 3'd0;
      for (int i = 0; i < 4; i++) begin
        win_r[i] <= 8'd0;
      end
    end else begin
      if (cfg_wr_en) begin
        scan_en_r <= cfg_wr_data;
      end
      cnt_r <= cnt_nxt;
      win_r <= win_nxt;
    end
  end

endmodule

// ----- rtl/lsdb_queue.sv -----
// Short op queue between front and back.
module lsdb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lsdb_pkg::op_t push_op,
  input  logic          pop,
  output logic          empty,
  output logic          full,
  output lsdb_pkg::op_t head_op
);

  lsdb_pkg::op_t                 mem_r [lsdb_pkg::QDEPTH];
  logic [lsdb_pkg::QPTR_W-1:0]   wptr_r, rptr_r;
  logic [lsdb_pkg::QCNT_W-1:0]   cnt_r;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == lsdb_pkg::QCNT_W'(lsdb_pkg::QDEPTH));
  assign head_op = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- rtl/lsdb_back.sv -----
// Back end: distance table, clearing pass and result register.
module lsdb_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  lsdb_pkg::op_t              q_head,
  output logic                       q_pop,
  output logic                       busy,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_result_kind,
  output logic [lsdb_pkg::BIN_W-1:0] out_angle_bin,
  output logic [15:0]                out_distance_raw,
  output logic [5:0]                 out_sample_quality,
  output logic                       out_scan_start
);

  logic [15:0]                 table_mem [lsdb_pkg::ANGLE_BINS];
  logic [15:0]                 rd_q;
  logic                        clr_r;
  logic [lsdb_pkg::BIN_W-1:0]  clr_addr_r;
  logic                        ov_r;
  lsdb_pkg::op_t               op_r;
  logic                        rng_r;

  logic                        wr_en;
  logic [lsdb_pkg::BIN_W-1:0]  wr_addr;
  logic [15:0]                 wr_data;
  logic                        rd_en;
  logic                        in_rng;

  assign busy   = clr_r;
  assign q_pop  = !clr_r && !q_empty && (!ov_r || !out_stall);
  assign in_rng = (q_head.bin < lsdb_pkg::BIN_LIMIT);
  assign rd_en  = q_pop && (q_head.kind == lsdb_pkg::KIND_READ) && in_rng;

  always_comb begin
    if (clr_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = 16'd0;
    end else begin
      wr_en   = q_pop && (q_head.kind == lsdb_pkg::KIND_SAMPLE);
      wr_addr = q_head.bin;
      wr_data = q_head.distance;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= table_mem[q_head.bin];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r  <= q_head;
      rng_r <= in_rng;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      ov_r       <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == lsdb_pkg::BIN_LAST) begin
          clr_r <= 1'b0;
        end
      end
      if (q_pop) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid          = ov_r;
  assign out_result_kind    = op_r.kind;
  assign out_angle_bin      = op_r.bin;
  assign out_distance_raw   = (op_r.kind == lsdb_pkg::KIND_READ) ?
                              (rng_r ? rd_q : 16'd0) : op_r.distance;
  assign out_sample_quality = op_r.quality;
  assign out_scan_start     = op_r.start;

endmodule
